### sv/llas_pkg.sv
// ----------------------------------------------------------------------------
// llas_pkg
// Shared types and constants of the life-like automaton step core: grid
// limits, command and register codes, and the item structs of both channels.
// ----------------------------------------------------------------------------
package llas_pkg;

    // Grid limits; the cell store holds one word of MAX_ROWS cells per column
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;

    // Word address and bit index into the cell store
    localparam int COL_AW = $clog2(MAX_COLS);
    localparam int ROW_AW = $clog2(MAX_ROWS);

    // Width of the size registers and of every size comparison
    localparam int CFG_DIM_W = 7;
    localparam int COL_DIM_W = $clog2(MAX_COLS + 1);
    localparam int ROW_DIM_W = $clog2(MAX_ROWS + 1);
    localparam int GRID_DIM_W = (COL_DIM_W > ROW_DIM_W) ? COL_DIM_W : ROW_DIM_W;
    localparam int DIM_W = (GRID_DIM_W > CFG_DIM_W) ? GRID_DIM_W : CFG_DIM_W;

    localparam int MASK_W = 9;
    localparam int CNT_W = 4;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_COLS    = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_BIRTH   = 2'd2;
    localparam logic [1:0] REG_SURVIVE = 2'd3;

    localparam logic [CFG_DIM_W-1:0] COLS_RESET    = 7'd64;
    localparam logic [CFG_DIM_W-1:0] ROWS_RESET    = 7'd64;
    localparam logic [MASK_W-1:0]    BIRTH_RESET   = 9'd8;
    localparam logic [MASK_W-1:0]    SURVIVE_RESET = 9'd12;

    // Command codes
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] col;
        logic [5:0] row;
        logic       cell_in;
    } t_in_item;

    typedef struct packed {
        logic cell_out;
        logic bad_coord;
    } t_out_item;

endpackage

### sv/life_like_automaton_step_core.sv
// ----------------------------------------------------------------------------
// life_like_automaton_step_core
// Grid of one-bit cells with write, read and advance commands; an advance
// computes one generation of a life-like automaton with a birth/survive rule.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// in        in         i_in_valid / o_in_ready      i_in  (t_in_item)
// out       out        o_out_valid / i_out_ready    o_out (t_out_item)
// config    in         psel, penable, pwrite        paddr, pwdata -> prdata
//
// A cell read or write is one memory read, then the
// read-modify-write of the column word.
// An advance walks the store one column word per cycle, bounded by its
// single read and single write port.
// Reset clears the column valid bits at once; no clearing pass is needed.
// A new item is taken while a finished result still waits in the output
// register; a second finished result is held until the first is taken.
// ----------------------------------------------------------------------------
module life_like_automaton_step_core
    import llas_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CELL  = 5'b00010,
        S_PRIME = 5'b00100,
        S_ADV   = 5'b01000,
        S_PEND  = 5'b10000
    } t_state;

    // Control and payload registers
    t_state                r_state, n_state;
    t_in_item              r_item;
    logic [MAX_ROWS-1:0]   r_prev, n_prev;
    logic [MAX_ROWS-1:0]   r_cur, n_cur;
    logic [COL_AW-1:0]     r_col, n_col;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;
    t_out_item             r_pend, n_pend;

    logic [CFG_DIM_W-1:0]  r_cols_in_use;
    logic [CFG_DIM_W-1:0]  r_rows_in_use;
    logic [MASK_W-1:0]     r_birth_mask;
    logic [MASK_W-1:0]     r_survive_mask;

    // Cell store: one word per column, valid bit per column
    logic [MAX_ROWS-1:0]   mem [MAX_COLS];
    logic [MAX_COLS-1:0]   r_col_ok;
    logic [MAX_ROWS-1:0]   r_rd_q;
    logic                  r_rd_ok;
    logic [MAX_ROWS-1:0]   rd_word;
    logic [COL_AW-1:0]     mem_ra;
    logic                  mem_we;
    logic [COL_AW-1:0]     mem_wa;
    logic [MAX_ROWS-1:0]   mem_wd;

    logic                  in_xfer;
    logic                  cfg_wr;
    logic [DIM_W-1:0]      eff_cols;
    logic [DIM_W-1:0]      eff_rows;
    logic [MAX_ROWS-1:0]   row_mask;
    logic                  coord_ok;
    logic [COL_AW-1:0]     item_col;
    logic [ROW_AW-1:0]     item_row;
    logic [MAX_ROWS-1:0]   cell_word;
    logic                  next_ok;
    logic [MAX_ROWS-1:0]   nb_prev;
    logic [MAX_ROWS-1:0]   nb_cur;
    logic [MAX_ROWS-1:0]   nb_next;
    logic [MAX_ROWS-1:0]   adv_word;
    logic [CNT_W-1:0]      nb_cnt [MAX_ROWS];
    logic                  fin;
    t_out_item             fin_res;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;

    // Clamp the grid size to the store
    assign eff_cols = (DIM_W'(r_cols_in_use) > DIM_W'(MAX_COLS)) ?
                      DIM_W'(MAX_COLS) : DIM_W'(r_cols_in_use);
    assign eff_rows = (DIM_W'(r_rows_in_use) > DIM_W'(MAX_ROWS)) ?
                      DIM_W'(MAX_ROWS) : DIM_W'(r_rows_in_use);

    always_comb begin
        for (int r = 0; r < MAX_ROWS; r++) begin
            row_mask[r] = DIM_W'(r) < eff_rows;
        end
    end

    // Read the configuration registers
    always_comb begin
        unique case (paddr[3:2])
            REG_COLS:    prdata = PDATA_W'(r_cols_in_use);
            REG_ROWS:    prdata = PDATA_W'(r_rows_in_use);
            REG_BIRTH:   prdata = PDATA_W'(r_birth_mask);
            REG_SURVIVE: prdata = PDATA_W'(r_survive_mask);
            default:     prdata = '0;
        endcase
    end

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_in_use  <= COLS_RESET;
            r_rows_in_use  <= ROWS_RESET;
            r_birth_mask   <= BIRTH_RESET;
            r_survive_mask <= SURVIVE_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_COLS:    r_cols_in_use  <= pwdata[CFG_DIM_W-1:0];
                REG_ROWS:    r_rows_in_use  <= pwdata[CFG_DIM_W-1:0];
                REG_BIRTH:   r_birth_mask   <= pwdata[MASK_W-1:0];
                REG_SURVIVE: r_survive_mask <= pwdata[MASK_W-1:0];
                default:     r_birth_mask   <= r_birth_mask;
            endcase
        end
    end

    // Cell store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_q <= mem[mem_ra];
    end

    // Column valid bits: a never-written column reads as all dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_col_ok[mem_wa] <= 1'b1;
            end
            r_rd_ok <= r_col_ok[mem_ra];
        end
    end

    assign rd_word = r_rd_ok ? r_rd_q : '0;

    // Coordinate check and cell update for read and write commands
    assign item_col  = COL_AW'(r_item.col);
    assign item_row  = ROW_AW'(r_item.row);
    assign coord_ok  = (DIM_W'(r_item.col) < eff_cols) && (DIM_W'(r_item.row) < eff_rows);

    always_comb begin
        cell_word           = rd_word;
        cell_word[item_row] = r_item.cell_in;
    end

    // Neighbour counts over the three-column window
    assign next_ok = (DIM_W'(r_col) + DIM_W'(1)) < eff_cols;
    assign nb_prev = r_prev & row_mask;
    assign nb_cur  = r_cur & row_mask;
    assign nb_next = next_ok ? (rd_word & row_mask) : '0;

    always_comb begin
        logic [MAX_ROWS-1:0] p_dn, p_up, c_dn, c_up, x_dn, x_up;
        p_dn = nb_prev << 1;
        p_up = nb_prev >> 1;
        c_dn = nb_cur << 1;
        c_up = nb_cur >> 1;
        x_dn = nb_next << 1;
        x_up = nb_next >> 1;
        for (int r = 0; r < MAX_ROWS; r++) begin
            nb_cnt[r] = CNT_W'(p_dn[r]) + CNT_W'(nb_prev[r]) + CNT_W'(p_up[r])
                      + CNT_W'(c_dn[r]) + CNT_W'(c_up[r])
                      + CNT_W'(x_dn[r]) + CNT_W'(nb_next[r]) + CNT_W'(x_up[r]);
            if (!row_mask[r]) begin
                adv_word[r] = r_cur[r];
            end else if (r_cur[r]) begin
                adv_word[r] = r_survive_mask[nb_cnt[r]];
            end else begin
                adv_word[r] = r_birth_mask[nb_cnt[r]];
            end
        end
    end

    // Sequencer: memory ports, column walk and result hand-off
    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_col       = r_col;
        n_pend      = r_pend;
        mem_ra      = r_col + COL_AW'(2);
        mem_we      = 1'b0;
        mem_wa      = r_col;
        mem_wd      = adv_word;
        fin         = 1'b0;
        fin_res     = '0;

        unique case (r_state)
            S_IDLE: begin
                mem_ra = (i_in.cmd == CMD_ADVANCE) ? '0 : COL_AW'(i_in.col);
                if (in_xfer) begin
                    n_state = (i_in.cmd == CMD_ADVANCE) ? S_PRIME : S_CELL;
                end
            end
            S_CELL: begin
                fin = 1'b1;
                if (r_item.cmd == CMD_WRITE || r_item.cmd == CMD_READ) begin
                    fin_res.bad_coord = !coord_ok;
                    fin_res.cell_out  = (r_item.cmd == CMD_READ) && coord_ok &&
                                        rd_word[item_row];
                    mem_we = (r_item.cmd == CMD_WRITE) && coord_ok;
                    mem_wa = item_col;
                    mem_wd = cell_word;
                end
            end
            S_PRIME: begin
                // load column 0 and fetch column 1
                mem_ra = COL_AW'(1);
                n_prev = '0;
                n_cur  = rd_word;
                n_col  = '0;
                if (eff_cols == '0) begin
                    fin = 1'b1;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                // write back the new column, slide the window
                mem_we = 1'b1;
                n_prev = r_cur;
                n_cur  = rd_word;
                n_col  = r_col + COL_AW'(1);
                if (!next_ok) begin
                    fin = 1'b1;
                end
            end
            S_PEND: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Drop the finished result into the output register or hold it
        if (fin) begin
            if (!r_out_valid || i_out_ready) begin
                n_state = S_IDLE;
            end else begin
                n_pend  = fin_res;
                n_state = S_PEND;
            end
        end
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (fin && (!r_out_valid || i_out_ready)) begin
            n_out_valid = 1'b1;
            n_out       = fin_res;
        end else if (r_state == S_PEND && (!r_out_valid || i_out_ready)) begin
            n_out_valid = 1'b1;
            n_out       = r_pend;
        end
    end

    // Hold state and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (in_xfer) begin
            r_item <= i_in;
        end
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_col  <= n_col;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

endmodule

### sv/llas_checker.sv
// ----------------------------------------------------------------------------
// llas_checker
// Port-level checks of the life-like automaton step core, bound to the top.
// ----------------------------------------------------------------------------
module llas_checker
    import llas_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input t_out_item          o_out,
    input logic               psel,
    input logic               penable,
    input logic               pready
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // A read that hits a live cell is never flagged
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.cell_out && o_out.bad_coord))
        else $error("cell value and bad coordinate both set");

    // Reset empties the result register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A taken command always leaves the core busy, not ready for the next one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command taken on two consecutive cycles");

    // The configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("configuration access stalled");

endmodule

bind life_like_automaton_step_core llas_checker u_llas_checker (.*);

### verif/life_like_automaton_step_core_tb.sv
// ----------------------------------------------------------------------------
// life_like_automaton_step_core_tb
// Self-checking bench for the life-like automaton step core. Cell writes,
// reads and generation advances are driven over the command channel. A
// model of the grid and rule predicts every reply, and each reply is checked
// field by field as it is taken. Grid size and rule masks are reprogrammed
// over the APB port between phases. The phases use varied idling and one
// long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module life_like_automaton_step_core_tb;
    import llas_pkg::*;

    // Spare command code, no effect on the grid
    localparam logic [1:0] CMD_SPARE = 2'd3;
    // Longest advance plus margin, used before register writes and at the end
    localparam int SETTLE_CYCLES = MAX_COLS + 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Grid and rule as the core should hold them
    bit [MAX_ROWS-1:0]  life_grid [MAX_COLS];
    bit [CFG_DIM_W-1:0] cols_cfg;
    bit [CFG_DIM_W-1:0] rows_cfg;
    bit [MASK_W-1:0]    birth_cfg;
    bit [MASK_W-1:0]    survive_cfg;

    t_out_item awaited_replies [$];
    int        mismatch_count    = 0;
    int        send_idle_pct     = 0;
    int        recv_stall_pct    = 0;
    int        ready_hold_cycles = 0;

    life_like_automaton_step_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Grid prediction
    // ------------------------------------------------------------------------
    function automatic int used_cols();
        return (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
    endfunction

    function automatic int used_rows();
        return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    endfunction

    // Compute one generation over the cells in use; the rest keep their value
    function automatic void next_generation();
        bit [MAX_ROWS-1:0] fresh [MAX_COLS];
        int nc, nr, live, c, r, dc, dr, tc, tr;
        nc = used_cols();
        nr = used_rows();
        fresh = life_grid;
        for (c = 0; c < nc; c++) begin
            for (r = 0; r < nr; r++) begin
                live = 0;
                for (dc = -1; dc <= 1; dc++) begin
                    for (dr = -1; dr <= 1; dr++) begin
                        tc = c + dc;
                        tr = r + dr;
                        // cells beyond the edge of the grid in use count as dead
                        if ((dc != 0 || dr != 0) && tc >= 0 && tc < nc && tr >= 0 && tr < nr)
                            live += life_grid[tc][tr];
                    end
                end
                fresh[c][r] = life_grid[c][r] ? survive_cfg[live] : birth_cfg[live];
            end
        end
        life_grid = fresh;
    endfunction

    // Apply one command to the predicted grid and return the reply it gives
    function automatic t_out_item apply_command(t_in_item item);
        t_out_item reply;
        bit        in_grid;
        reply = '0;
        in_grid = (item.col < used_cols()) && (item.row < used_rows());
        case (item.cmd)
            CMD_WRITE, CMD_READ: begin
                if (!in_grid)
                    reply.bad_coord = 1'b1;
                else if (item.cmd == CMD_WRITE)
                    life_grid[item.col][item.row] = item.cell_in;
                else
                    reply.cell_out = life_grid[item.col][item.row];
            end
            CMD_ADVANCE: next_generation();
            default: ;
        endcase
        return reply;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready pattern with optional long hold-off, reply checking
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (ready_hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            ready_hold_cycles--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_replies.size() == 0) begin
                $error("unexpected reply: cell_out %0d bad_coord %0d",
                       o_out.cell_out, o_out.bad_coord);
                mismatch_count++;
            end else begin
                want = awaited_replies.pop_front();
                if (o_out.cell_out !== want.cell_out) begin
                    $error("cell_out: expected %0d, got %0d", want.cell_out, o_out.cell_out);
                    mismatch_count++;
                end
                if (o_out.bad_coord !== want.bad_coord) begin
                    $error("bad_coord: expected %0d, got %0d", want.bad_coord, o_out.bad_coord);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    // Offer one command, keeping valid high across back-to-back transfers
    task automatic send_cmd(logic [1:0] cmd, logic [5:0] col, logic [5:0] row,
                            logic cell_in);
        t_in_item item;
        item = '{cmd: cmd, col: col, row: row, cell_in: cell_in};
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        awaited_replies.push_back(apply_command(item));
    endtask

    // Mostly in-grid coordinates, some anywhere in the field range
    task automatic send_random_command();
        int         pick, nc, nr;
        logic [1:0] cmd;
        logic [5:0] col, row;
        pick = $urandom_range(99);
        cmd = (pick < 45) ? CMD_WRITE :
              (pick < 80) ? CMD_READ  :
              (pick < 95) ? CMD_ADVANCE : CMD_SPARE;
        nc = used_cols();
        nr = used_rows();
        if (nc > 0 && nr > 0 && $urandom_range(99) < 85) begin
            col = 6'($urandom_range(nc - 1, 0));
            row = 6'($urandom_range(nr - 1, 0));
        end else begin
            col = 6'($urandom_range(63));
            row = 6'($urandom_range(63));
        end
        send_cmd(cmd, col, row, 1'($urandom_range(1)));
    endtask

    // Drop valid, wait for every reply, then let any advance finish
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------------
    task automatic reg_write(logic [1:0] index, logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (index)
            REG_COLS:    cols_cfg    = value[CFG_DIM_W-1:0];
            REG_ROWS:    rows_cfg    = value[CFG_DIM_W-1:0];
            REG_BIRTH:   birth_cfg   = value[MASK_W-1:0];
            REG_SURVIVE: survive_cfg = value[MASK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read_check(logic [1:0] index);
        logic [PDATA_W-1:0] want;
        case (index)
            REG_COLS:    want = PDATA_W'(cols_cfg);
            REG_ROWS:    want = PDATA_W'(rows_cfg);
            REG_BIRTH:   want = PDATA_W'(birth_cfg);
            default:     want = PDATA_W'(survive_cfg);
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            $error("register %0d: expected %0h, got %0h", index, want, prdata);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        reg_read_check(REG_COLS);
        reg_read_check(REG_ROWS);
        reg_read_check(REG_BIRTH);
        reg_read_check(REG_SURVIVE);
    endtask

    // Reprogram size and rule once the core is idle, then read them back
    task automatic program_rule(logic [PDATA_W-1:0] cols, logic [PDATA_W-1:0] rows,
                                logic [PDATA_W-1:0] birth, logic [PDATA_W-1:0] survive);
        quiesce();
        reg_write(REG_COLS, cols);
        reg_write(REG_ROWS, rows);
        reg_write(REG_BIRTH, birth);
        reg_write(REG_SURVIVE, survive);
        check_registers();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset values, corner cells, overwrite and the spare command
    task automatic test_cell_access();
        check_registers();
        send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0);
        send_cmd(CMD_WRITE, 6'd0, 6'd0, 1'b1);
        send_cmd(CMD_WRITE, 6'd63, 6'd63, 1'b1);
        send_cmd(CMD_WRITE, 6'd63, 6'd0, 1'b1);
        send_cmd(CMD_WRITE, 6'd0, 6'd63, 1'b1);
        send_cmd(CMD_READ, 6'd63, 6'd63, 1'b0);
        send_cmd(CMD_WRITE, 6'd0, 6'd0, 1'b0);
        send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0);
        send_cmd(CMD_SPARE, 6'd63, 6'd63, 1'b1);
        send_cmd(CMD_READ, 6'd63, 6'd63, 1'b0);
    endtask

    // Blinker on a small grid under the standard rule, two generations
    task automatic test_blinker();
        program_rule(5, 5, 8, 12);
        send_cmd(CMD_WRITE, 6'd1, 6'd2, 1'b1);
        send_cmd(CMD_WRITE, 6'd2, 6'd2, 1'b1);
        send_cmd(CMD_WRITE, 6'd3, 6'd2, 1'b1);
        send_cmd(CMD_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_cmd(CMD_READ, 6'd2, 6'd1, 1'b0);
        send_cmd(CMD_READ, 6'd1, 6'd2, 1'b0);
        send_cmd(CMD_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_cmd(CMD_READ, 6'd1, 6'd2, 1'b0);
    endtask

    // Zero size, oversize and single-cell grids; cells outside keep their value
    task automatic test_size_limits();
        program_rule(0, 64, 8, 12);
        send_cmd(CMD_WRITE, 6'd0, 6'd0, 1'b1);
        send_cmd(CMD_READ, 6'd0, 6'd0, 1'b0);
        send_cmd(CMD_ADVANCE, 6'd0, 6'd0, 1'b0);
        program_rule(1, 1, 0, 0);
        send_cmd(CMD_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_cmd(CMD_WRITE, 6'd1, 6'd0, 1'b1);
        program_rule(100, 127, 8, 12);
        send_cmd(CMD_READ, 6'd63, 6'd63, 1'b0);
    endtask

    task automatic test_random_traffic(int count, int cols, int rows, int birth,
                                       int survive, int idle_pct, int stall_pct);
        program_rule(cols, rows, birth, survive);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_command();
    endtask

    // Hold the result side off while commands keep coming, so the core stalls
    task automatic test_backpressure();
        program_rule(6, 6, 8, 12);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        ready_hold_cycles = 300;
        repeat (40) send_random_command();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cols_cfg    = COLS_RESET;
        rows_cfg    = ROWS_RESET;
        birth_cfg   = BIRTH_RESET;
        survive_cfg = SURVIVE_RESET;
        foreach (life_grid[c]) life_grid[c] = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_cell_access();
        test_blinker();
        test_size_limits();
        test_random_traffic(110, 8, 8, 8, 12, 0, 0);
        test_random_traffic(100, 5, 7, $urandom_range(511), $urandom_range(511), 51, 0);
        test_random_traffic(90, 64, 64, 8, 12, 0, 51);
        test_random_traffic(70, 1, 64, $urandom_range(511), $urandom_range(511), 33, 33);
        test_random_traffic(70, 64, 1, $urandom_range(511), $urandom_range(511), 33, 33);
        test_random_traffic(70, 12, 10, 511, 0, 0, 0);
        test_random_traffic(50, 3, 3, 0, 511, 51, 0);
        test_random_traffic(30, 0, 0, $urandom_range(511), $urandom_range(511), 0, 51);
        test_random_traffic(50, 127, 65, $urandom_range(511), $urandom_range(511), 33, 33);
        test_random_traffic(80, $urandom_range(16, 2), $urandom_range(16, 2),
                            $urandom_range(511), $urandom_range(511), 33, 33);
        test_backpressure();

        quiesce();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Guard against a hang
    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
